### rtl/core/msc_pkg.sv
package msc_pkg;

  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 16;
  localparam int LEN_W   = 16;
  localparam int MAX_RES = 3;
  localparam int RES_W   = $clog2(MAX_RES + 1);

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(512);

  // Byte codes the filter reacts to
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEAD  = 8'hC2;
  localparam logic [BYTE_W-1:0] CH_TRAIL = 8'hB6;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  // Results produced by one accepted input word
  typedef struct packed {
    logic [RES_W-1:0]               cnt;
    logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
    logic                           bare;
    logic                           last;
  } group_t;

endpackage

### rtl/core/msc_if.sv
interface msc_in_if;
  import msc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface msc_out_if;
  import msc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_valid;
  logic              out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input out_valid, input out_last,
                output ready);
endinterface

interface msc_cfg_if;
  import msc_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] max_len;

  modport source (output valid, output max_len, input ready);
  modport sink (input valid, input max_len, output ready);
endinterface

### rtl/core/markup_strip_space_collapse.sv
// Output: an accepted byte shows its first result word on tx in the cycle after acceptance.
// Throughput: one input byte per cycle while each byte yields at most one word and tx is
//   ready; a byte yielding two or three words (held space, released 0xC2) holds rx until
//   the three-word result queue, draining one word per ready cycle, reaches its last word.
// Reset (rst, synchronous, active high): clear tag/space/lead/count state, empty the
//   result queue, and load max_len with 512. No clearing pass is needed.
module markup_strip_space_collapse (
  input  logic      clk,
  input  logic      rst,
  msc_in_if.sink    rx,
  msc_out_if.source tx,
  msc_cfg_if.sink   cfg
);
  import msc_pkg::*;

  group_t grp;
  logic   ready;
  logic   accept;

  // Accept a byte when the result queue is empty or loses its last word this cycle
  assign rx.ready = ready;
  assign accept   = rx.valid && ready;

  // Filter: tag stripping, pilcrow removal, space collapsing and length limit,
  // all worked out in one pass for the byte on rx
  msc_filter u_filter (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .in_byte (rx.in_byte),
    .in_last (rx.in_last),
    .grp     (grp)
  );

  // Result register: hold up to three words and hand them out one at a time
  msc_serializer u_serializer (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .grp   (grp),
    .ready (ready),
    .tx    (tx)
  );

endmodule

### rtl/core/msc_filter.sv
module msc_filter (
  input  logic                      clk,
  input  logic                      rst,
  msc_cfg_if.sink                   cfg,
  input  logic                      accept,
  input  logic [msc_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_last,
  output msc_pkg::group_t           grp
);
  import msc_pkg::*;

  logic [LEN_W-1:0] max_len;
  logic             inside_tag;
  logic             space_pending;
  logic             lead_held;
  logic [CNT_W-1:0] written_count;

  logic             tag_next;
  logic             sp_next;
  logic             held_next;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] lim;

  assign cfg.ready = 1'b1;
  assign lim = (max_len == '0) ? '0 : CNT_W'(max_len - LEN_W'(1));

  always_comb begin
    logic                           tag_v;
    logic                           sp_v;
    logic                           held_v;
    logic                           take_v;
    logic [CNT_W-1:0]               cnt_v;
    logic [RES_W-1:0]               n_v;
    logic [MAX_RES-1:0][BYTE_W-1:0] res_v;

    tag_v  = inside_tag;
    sp_v   = space_pending;
    held_v = 1'b0;
    take_v = 1'b1;
    cnt_v  = written_count;
    n_v    = '0;
    res_v  = '0;

    // release a held lead byte, or drop it with its trail byte
    if (lead_held) begin
      if (in_byte == CH_TRAIL) begin
        take_v = 1'b0;
      end else if (cnt_v < lim) begin
        if (sp_v) begin
          res_v[n_v[1:0]] = CH_SPACE;
          n_v  = n_v + RES_W'(1);
          sp_v = 1'b0;
        end
        res_v[n_v[1:0]] = CH_LEAD;
        n_v   = n_v + RES_W'(1);
        cnt_v = cnt_v + CNT_W'(1);
      end
    end

    // handle the new byte itself
    if (take_v && (cnt_v < lim)) begin
      if (in_byte == CH_OPEN) begin
        tag_v = 1'b1;
      end else if (in_byte == CH_CLOSE) begin
        tag_v = 1'b0;
      end else if (!tag_v) begin
        if (in_byte == CH_LEAD) begin
          held_v = 1'b1;
        end else if (in_byte inside {CH_NL, CH_CR, CH_TAB, CH_SPACE}) begin
          if (!sp_v) begin
            sp_v  = 1'b1;
            cnt_v = cnt_v + CNT_W'(1);
          end
        end else begin
          if (sp_v) begin
            res_v[n_v[1:0]] = CH_SPACE;
            n_v  = n_v + RES_W'(1);
            sp_v = 1'b0;
          end
          res_v[n_v[1:0]] = in_byte;
          n_v   = n_v + RES_W'(1);
          cnt_v = cnt_v + CNT_W'(1);
        end
      end
    end

    // end of text: flush a lead byte that no trail byte can follow
    if (in_last && held_v) begin
      held_v = 1'b0;
      if (cnt_v < lim) begin
        if (sp_v) begin
          res_v[n_v[1:0]] = CH_SPACE;
          n_v  = n_v + RES_W'(1);
          sp_v = 1'b0;
        end
        res_v[n_v[1:0]] = CH_LEAD;
        n_v   = n_v + RES_W'(1);
        cnt_v = cnt_v + CNT_W'(1);
      end
    end

    grp.last = in_last;
    if (in_last && (n_v == '0)) begin
      grp.cnt   = RES_W'(1);
      grp.bytes = '0;
      grp.bare  = 1'b1;
    end else begin
      grp.cnt   = n_v;
      grp.bytes = res_v;
      grp.bare  = 1'b0;
    end

    if (in_last) begin
      tag_next  = 1'b0;
      sp_next   = 1'b0;
      held_next = 1'b0;
      cnt_next  = '0;
    end else begin
      tag_next  = tag_v;
      sp_next   = sp_v;
      held_next = held_v;
      cnt_next  = cnt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len       <= MAX_LEN_RESET;
      inside_tag    <= 1'b0;
      space_pending <= 1'b0;
      lead_held     <= 1'b0;
      written_count <= '0;
    end else begin
      if (cfg.valid) begin
        max_len <= cfg.max_len;
      end
      if (accept) begin
        inside_tag    <= tag_next;
        space_pending <= sp_next;
        lead_held     <= held_next;
        written_count <= cnt_next;
      end
    end
  end

  a_held_outside_tag: assert property (@(posedge clk) disable iff (rst)
    !(lead_held && inside_tag))
    else $error("lead byte held inside markup");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> (written_count == '0) && !space_pending && !lead_held
                          && !inside_tag)
    else $error("state not cleared after end of text");

  a_group_fits: assert property (@(posedge clk) disable iff (rst)
    accept |-> (grp.cnt <= RES_W'(MAX_RES)))
    else $error("more result words than the queue holds");

endmodule

### rtl/core/msc_serializer.sv
module msc_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  msc_pkg::group_t grp,
  output logic            ready,
  msc_out_if.source       tx
);
  import msc_pkg::*;

  logic [RES_W-1:0]               rem;
  logic [MAX_RES-1:0][BYTE_W-1:0] data;
  logic                           bare;
  logic                           last;
  logic                           pop;

  assign pop   = tx.valid && tx.ready;
  assign ready = (rem == '0) || ((rem == RES_W'(1)) && tx.ready);

  assign tx.valid     = (rem != '0);
  assign tx.out_byte  = data[0];
  assign tx.out_valid = !bare;
  assign tx.out_last  = last && (rem == RES_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= grp.cnt;
    end else if (pop) begin
      rem <= rem - RES_W'(1);
    end
  end

  // load a new group, else advance the byte queue on each delivered word
  always_ff @(posedge clk) begin
    if (load) begin
      data <= grp.bytes;
      bare <= grp.bare;
      last <= grp.last;
    end else if (pop) begin
      data <= {BYTE_W'(0), data[MAX_RES-1:1]};
    end
  end

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    (rem > RES_W'(1)) |-> !ready)
    else $error("input taken while several results pending");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load && (grp.cnt != '0) |=> tx.valid)
    else $error("loaded group not presented");

  a_bare_single: assert property (@(posedge clk) disable iff (rst)
    tx.valid && bare |-> (rem == RES_W'(1)) && last)
    else $error("end marker not alone or not last");

endmodule

### verif/markup_strip_space_collapse_tb.sv
`timescale 1ns / 1ps

module markup_strip_space_collapse_tb;
  import msc_pkg::*;

  // Give up after this many cycles with no word moving on any channel.
  localparam int IDLE_LIMIT     = 1000;
  // Cycles to let the result queue settle once nothing is outstanding.
  localparam int SETTLE_CYCLES  = 4;
  localparam int PRINT_CAP      = 30;
  localparam int N_DIRECTED     = 23;
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 51;

  // One result word as the block should present it on tx.
  typedef struct packed {
    logic [BYTE_W-1:0] ob;
    logic              ov;
    logic              ol;
  } clean_word_t;

  // One row of stimulus. Rows with known = 1 carry the single word they must produce.
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              l;
    logic              known;
    logic [BYTE_W-1:0] eb;
    logic              ev;
    logic              el;
  } stim_row_t;

  logic clk;
  logic rst;

  msc_in_if  in_ch();
  msc_out_if out_ch();
  msc_cfg_if cfg_ch();

  markup_strip_space_collapse dut (
    .clk (clk),
    .rst (rst),
    .rx  (in_ch),
    .tx  (out_ch),
    .cfg (cfg_ch)
  );

  // Shadow of the filter: configuration and text state.
  logic [LEN_W-1:0] len_reg;
  logic             in_tag;
  logic             space_held;
  logic             lead_held;
  logic [CNT_W-1:0] kept_cnt;

  clean_word_t step_words[$];     // words caused by the byte being predicted
  clean_word_t pending_clean[$];  // words still owed by the block, oldest first

  int  mismatches;
  bit  calm;           // no idling on either side
  bit  gappy;          // sender inserts gaps in the current text
  bit  rx_stall_mode;  // receiver drops ready in bursts

  // Directed rows, walked at the reset value of max_len (512).
  stim_row_t dir_rows [N_DIRECTED] = '{
    // first byte after reset comes straight through
    '{8'h41,     1'b0, 1'b1, 8'h41, 1'b1, 1'b0},
    // zero byte is an ordinary character
    '{8'h00,     1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
    '{8'hFF,     1'b0, 1'b1, 8'hFF, 1'b1, 1'b0},
    // space held, tab folds into it, next letter releases it
    '{CH_SPACE,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_TAB,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h62,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_NL,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // markup swallows everything up to the close
    '{CH_OPEN,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h78,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_SPACE,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_CLOSE,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // bare close is dropped
    '{CH_CLOSE,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // pilcrow pair vanishes
    '{CH_LEAD,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_TRAIL,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // lead byte released by a letter with a space still held: three words
    '{CH_LEAD,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h7A,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_CR,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // lead byte as final byte is flushed with last
    '{CH_LEAD,   1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    // final byte that emits nothing gives a bare end marker
    '{CH_OPEN,   1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
    '{CH_SPACE,  1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
    // held lead byte released by a final open
    '{CH_LEAD,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_OPEN,   1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    // lone trail byte is an ordinary character
    '{CH_TRAIL,  1'b1, 1'b1, CH_TRAIL, 1'b1, 1'b1}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic bit has_room();
    logic [LEN_W:0] cap;
    // zero max_len acts as one: no room at all
    cap = (len_reg == '0) ? '0 : {1'b0, len_reg} - 1'b1;
    return {1'b0, kept_cnt} < cap;
  endfunction

  task automatic emit_byte(input logic [BYTE_W-1:0] b);
    clean_word_t w;
    w.ob = b;
    w.ov = 1'b1;
    w.ol = 1'b0;
    step_words.push_back(w);
  endtask

  // Place one character in the output; a space only marks itself held.
  task automatic place_char(input logic [BYTE_W-1:0] c);
    if (c == CH_SPACE) begin
      if (!space_held) begin
        space_held = 1'b1;
        kept_cnt++;
      end
    end else begin
      if (space_held) begin
        emit_byte(CH_SPACE);
        space_held = 1'b0;
      end
      emit_byte(c);
      kept_cnt++;
    end
  endtask

  task automatic filter_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = b;
    if (!has_room()) begin
      // limit reached: drop everything, markup included
    end else if (c == CH_OPEN) begin
      in_tag = 1'b1;
    end else if (c == CH_CLOSE) begin
      in_tag = 1'b0;
    end else if (!in_tag) begin
      if (c == CH_LEAD) begin
        lead_held = 1'b1;
      end else begin
        if (c == CH_NL || c == CH_CR || c == CH_TAB) c = CH_SPACE;
        place_char(c);
      end
    end
  endtask

  // Work out the words one accepted byte causes and leave them in step_words.
  task automatic predict_clean(input logic [BYTE_W-1:0] b, input logic l);
    clean_word_t w;
    step_words.delete();
    if (lead_held) begin
      lead_held = 1'b0;
      // a trail byte kills the pair; anything else frees the lead byte first
      if (b != CH_TRAIL) begin
        if (has_room()) place_char(CH_LEAD);
        filter_byte(b);
      end
    end else begin
      filter_byte(b);
    end
    if (l) begin
      if (lead_held) begin
        lead_held = 1'b0;
        if (has_room()) place_char(CH_LEAD);
      end
      if (step_words.size() == 0) begin
        w.ob = '0;
        w.ov = 1'b0;
        w.ol = 1'b1;
      end else begin
        w = step_words.pop_back();
        w.ol = 1'b1;
      end
      step_words.push_back(w);
      // the trailing held space dies with the text
      in_tag     = 1'b0;
      space_held = 1'b0;
      kept_cnt   = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Present one byte, hold it until taken, then book what it must produce.
  // Valid is left high on return; the next caller replaces or lowers it.
  task automatic send_word(input stim_row_t r);
    clean_word_t w;
    int gap;
    if (!calm && gappy && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= r.b;
    in_ch.in_last <= r.l;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_clean(r.b, r.l);
    if (r.known) begin
      w.ob = r.eb;
      w.ov = r.ev;
      w.ol = r.el;
      pending_clean.push_back(w);
    end else begin
      foreach (step_words[i]) pending_clean.push_back(step_words[i]);
    end
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed word has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_clean.size() != 0);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] v);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.max_len <= v;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    len_reg = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(input logic [BYTE_W-1:0] prev);
    // favor the pilcrow pair right after a lead byte
    if (prev == CH_LEAD && $urandom_range(0, 1) == 1) return CH_TRAIL;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: return BYTE_W'($urandom_range(8'h61, 8'h7A));
      8, 9:                    return CH_SPACE;
      10: begin
        case ($urandom_range(0, 2))
          0:       return CH_NL;
          1:       return CH_CR;
          default: return CH_TAB;
        endcase
      end
      11:      return CH_OPEN;
      12:      return CH_CLOSE;
      13:      return CH_LEAD;
      14:      return CH_TRAIL;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Send whole texts of random content until the budget is spent.
  task automatic run_texts(input int budget);
    stim_row_t         r;
    logic [BYTE_W-1:0] prev;
    int                sent;
    int                len;
    sent = 0;
    prev = '0;
    while (sent < budget) begin
      // mostly short texts, now and then a long one to hit the length limit
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      // cut the last text short so the budget is met exactly
      if (len > budget - sent) len = budget - sent;
      gappy = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++) begin
        r       = '0;
        r.b     = pick_byte(prev);
        prev    = r.b;
        // rare stray end marks break texts in odd places
        r.l     = (i == len - 1) || ($urandom_range(0, 40) == 0);
        send_word(r);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stalls
  // ---------------------------------------------------------------------------

  initial begin
    int stall;
    int age;
    stall = 0;
    age   = 0;
    rx_stall_mode = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      // switch between stretches with and without stalls
      age++;
      if (age == 40) begin
        age = 0;
        rx_stall_mode = ($urandom_range(0, 2) != 0);
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!calm && rx_stall_mode && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    clean_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_clean.size() == 0) begin
        report_mismatch("unexpected word", out_ch.out_byte, 0);
      end else begin
        want = pending_clean.pop_front();
        if (out_ch.out_byte !== want.ob) report_mismatch("out_byte", out_ch.out_byte, want.ob);
        if (out_ch.out_valid !== want.ov) report_mismatch("out_valid", out_ch.out_valid, want.ov);
        if (out_ch.out_last !== want.ol) report_mismatch("out_last", out_ch.out_last, want.ol);
      end
    end
  end

  // Watchdog: count cycles in which no word moves on any channel.
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("markup_strip_space_collapse_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------

  initial begin
    logic [LEN_W-1:0] len_plan [N_PHASES];
    mismatches     = 0;
    calm           = 1'b0;
    gappy          = 1'b0;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    in_ch.in_last  = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.max_len = '0;
    len_reg        = MAX_LEN_RESET;
    in_tag         = 1'b0;
    space_held     = 1'b0;
    lead_held      = 1'b0;
    kept_cnt       = '0;

    // Walk the small settings, the largest, a random mid value and the reset value; the last one runs calm.
    len_plan = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd6, 16'hFFFF,
                 LEN_W'($urandom_range(7, 30)), MAX_LEN_RESET};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset setting, with gaps in play.
    gappy = 1'b1;
    foreach (dir_rows[i]) send_word(dir_rows[i]);

    for (int p = 0; p < N_PHASES; p++) begin
      // Let the block go idle before touching max_len.
      drain();
      repeat (SETTLE_CYCLES) @(negedge clk);
      calm = (p == N_PHASES - 1);
      write_max_len(len_plan[p]);
      if (p == 4) begin
        // Hold the sender mid-phase until the block has caught up.
        run_texts(PHASE_ITEMS / 2);
        drain();
        run_texts(PHASE_ITEMS / 2);
      end else begin
        run_texts(PHASE_ITEMS);
      end
    end

    drain();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatches == 0 && pending_clean.size() == 0) begin
      $display("markup_strip_space_collapse_tb OK");
    end else begin
      $display("markup_strip_space_collapse_tb NOT OK");
    end
    $finish;
  end

endmodule
